// ===== hw/rtl/hpq_pkg.sv =====
// shared types and constants for the binary min-heap priority queue
// no dependencies; compiled first

package hpq_pkg;

  localparam int HPQ_HEAP_DEPTH = 64;
  localparam int HPQ_DATA_WIDTH = 32;
  localparam int HPQ_PRIO_WIDTH = 16;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    start;
    logic    read_parent;
    logic    move_up;
    logic    place_new;
    logic    read_ends;
    logic    load_last;
    logic    read_kids;
    logic    move_down;
    logic    place_last;
    logic    publish;
    status_t code;
  } hpq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic no_kids;
    logic go_up;
    logic go_down;
    logic out_busy;
  } hpq_stat_t;

endpackage

// ===== hw/rtl/hpq_in_if.sv =====
// request channel of the priority queue: action, data and priority
// depends on hpq_pkg

interface hpq_in_if #(
  parameter int DATA_WIDTH     = hpq_pkg::HPQ_DATA_WIDTH,
  parameter int PRIORITY_WIDTH = hpq_pkg::HPQ_PRIO_WIDTH
) ();
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [DATA_WIDTH-1:0]     item_data;
  logic [PRIORITY_WIDTH-1:0] item_priority;

  modport source (output valid, action, item_data, item_priority, input ready);
  modport sink   (input valid, action, item_data, item_priority, output ready);
endinterface

// ===== hw/rtl/hpq_out_if.sv =====
// result channel of the priority queue: data, status, count, empty flag
// depends on hpq_pkg

interface hpq_out_if #(
  parameter int DATA_WIDTH  = hpq_pkg::HPQ_DATA_WIDTH,
  parameter int COUNT_WIDTH = $clog2(hpq_pkg::HPQ_HEAP_DEPTH + 1)
) ();
  logic                   valid;
  logic                   ready;
  logic [DATA_WIDTH-1:0]  out_data;
  hpq_pkg::status_t       status;
  logic [COUNT_WIDTH-1:0] count;
  logic                   is_empty;

  modport source (output valid, out_data, status, count, is_empty, input ready);
  modport sink   (input valid, out_data, status, count, is_empty, output ready);
endinterface

// ===== hw/rtl/binary_min_heap_priority_queue.sv =====
// Binary min-heap priority queue, lower priority number served first.
// Request channel req: action 0 inserts {item_data, item_priority},
// action 1 removes the root and returns its data. Result channel rsp
// carries out_data, status (ok, insert refused full, delete refused
// empty), count after the item and is_empty. One result per item.
// An insert sifts up; a delete first reads the root and the last element,
// then sifts down. Each level the element moves takes a store read then
// a compare and write on the one heap store. A refused item goes straight
// to its result, and the next item is accepted the cycle after a result
// is registered.
// One item is worked on at a time; req.ready is high only while idle.
// The result sits in an output register: a stalled receiver holds it
// and the block still accepts and works the next item, then waits to publish.
// Synchronous reset empties the heap (count zero) and drops any pending
// result; store contents are not cleared.
// depends on hpq_pkg, hpq_in_if, hpq_out_if, hpq_ctrl, hpq_datapath

module binary_min_heap_priority_queue #(
  parameter int HEAP_DEPTH     = hpq_pkg::HPQ_HEAP_DEPTH,
  parameter int DATA_WIDTH     = hpq_pkg::HPQ_DATA_WIDTH,
  parameter int PRIORITY_WIDTH = hpq_pkg::HPQ_PRIO_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  hpq_in_if.sink    req,
  hpq_out_if.source rsp
);
  import hpq_pkg::*;

  localparam int COUNT_WIDTH = $clog2(HEAP_DEPTH + 1);

  hpq_cmd_t               cmd;
  hpq_stat_t              stat;
  logic                   out_valid;
  logic [DATA_WIDTH-1:0]  out_data;
  status_t                out_status;
  logic [COUNT_WIDTH-1:0] out_count;
  logic                   out_empty;

  hpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .action   (req.action),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hpq_datapath #(
    .HEAP_DEPTH     (HEAP_DEPTH),
    .DATA_WIDTH     (DATA_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .item_data     (req.item_data),
    .item_priority (req.item_priority),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (rsp.ready),
    .out_data      (out_data),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_empty     (out_empty)
  );

  assign rsp.valid    = out_valid;
  assign rsp.out_data = out_data;
  assign rsp.status   = out_status;
  assign rsp.count    = out_count;
  assign rsp.is_empty = out_empty;

endmodule

// ===== hw/rtl/hpq_ctrl.sv =====
// sequencer for insert sift-up and delete sift-down
// depends on hpq_pkg; drives hpq_datapath through hpq_cmd_t

module hpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               action,
  output logic               in_ready,
  input  hpq_pkg::hpq_stat_t stat,
  output hpq_pkg::hpq_cmd_t  cmd
);
  import hpq_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    INS_RD,
    INS_CMP,
    DEL_LOAD,
    DEL_RD,
    DEL_CMP,
    FINISH
  } state_t;

  state_t  state, state_next;
  status_t code, code_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    cmd.code   = code;
    state_next = state;
    code_next  = code;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          code_next = STATUS_OK;
          if (!action) begin
            if (stat.full) begin
              code_next  = STATUS_FULL;
              state_next = FINISH;
            end else begin
              state_next = INS_RD;
            end
          end else begin
            if (stat.empty) begin
              code_next  = STATUS_EMPTY;
              state_next = FINISH;
            end else begin
              cmd.read_ends = 1'b1;
              state_next    = DEL_LOAD;
            end
          end
        end
      end
      INS_RD: begin
        if (stat.at_root) begin
          cmd.place_new = 1'b1;
          state_next    = FINISH;
        end else begin
          cmd.read_parent = 1'b1;
          state_next      = INS_CMP;
        end
      end
      INS_CMP: begin
        if (stat.go_up) begin
          cmd.move_up = 1'b1;
          state_next  = INS_RD;
        end else begin
          cmd.place_new = 1'b1;
          state_next    = FINISH;
        end
      end
      DEL_LOAD: begin
        cmd.load_last = 1'b1;
        state_next    = DEL_RD;
      end
      DEL_RD: begin
        if (stat.no_kids) begin
          cmd.place_last = 1'b1;
          state_next     = FINISH;
        end else begin
          cmd.read_kids = 1'b1;
          state_next    = DEL_CMP;
        end
      end
      DEL_CMP: begin
        if (stat.go_down) begin
          cmd.move_down = 1'b1;
          state_next    = DEL_RD;
        end else begin
          cmd.place_last = 1'b1;
          state_next     = FINISH;
        end
      end
      FINISH: begin
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      code  <= STATUS_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule

// ===== hw/rtl/hpq_datapath.sv =====
// heap store, element count, sift registers and result register
// depends on hpq_pkg; commanded by hpq_ctrl

module hpq_datapath #(
  parameter int HEAP_DEPTH     = hpq_pkg::HPQ_HEAP_DEPTH,
  parameter int DATA_WIDTH     = hpq_pkg::HPQ_DATA_WIDTH,
  parameter int PRIORITY_WIDTH = hpq_pkg::HPQ_PRIO_WIDTH,
  localparam int COUNT_WIDTH   = $clog2(HEAP_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [DATA_WIDTH-1:0]     item_data,
  input  logic [PRIORITY_WIDTH-1:0] item_priority,
  input  hpq_pkg::hpq_cmd_t         cmd,
  output hpq_pkg::hpq_stat_t        stat,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [DATA_WIDTH-1:0]     out_data,
  output hpq_pkg::status_t          out_status,
  output logic [COUNT_WIDTH-1:0]    out_count,
  output logic                      out_empty
);
  import hpq_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int EW = DATA_WIDTH + PRIORITY_WIDTH;

  // slot i of the heap (1-based) lives at address i-1
  function automatic logic [AW-1:0] slot(input logic [COUNT_WIDTH-1:0] p);
    logic [COUNT_WIDTH-1:0] t;
    t = p - COUNT_WIDTH'(1);
    return t[AW-1:0];
  endfunction

  logic [EW-1:0]             mem [HEAP_DEPTH];
  logic [EW-1:0]             rd_a, rd_b;
  logic [EW-1:0]             elem;
  logic [COUNT_WIDTH-1:0]    pos;
  logic [COUNT_WIDTH-1:0]    count;
  logic [DATA_WIDTH-1:0]     top_data;

  logic [COUNT_WIDTH-1:0]    pos_m1;
  logic [COUNT_WIDTH:0]      left_pos, right_pos, count_ext, left_addr_w;
  logic                      right_ok, pick_right;
  logic [PRIORITY_WIDTH-1:0] elem_prio, a_prio, b_prio;
  logic [EW-1:0]             child_elem;
  logic [COUNT_WIDTH-1:0]    child_pos;
  logic [AW-1:0]             addr_a, addr_b, wr_addr;
  logic [EW-1:0]             wr_data;
  logic                      wr_en;

  assign pos_m1      = pos - COUNT_WIDTH'(1);
  assign left_pos    = {pos, 1'b0};
  assign right_pos   = {pos, 1'b1};
  assign count_ext   = {1'b0, count};
  assign left_addr_w = {pos_m1, 1'b1};
  assign right_ok    = (right_pos <= count_ext);

  assign elem_prio = elem[EW-1 -: PRIORITY_WIDTH];
  assign a_prio    = rd_a[EW-1 -: PRIORITY_WIDTH];
  assign b_prio    = rd_b[EW-1 -: PRIORITY_WIDTH];

  // left child wins a tie
  assign pick_right = right_ok && (a_prio > b_prio);
  assign child_elem = pick_right ? rd_b : rd_a;
  assign child_pos  = pick_right ? right_pos[COUNT_WIDTH-1:0] : left_pos[COUNT_WIDTH-1:0];

  assign stat.full     = (count == COUNT_WIDTH'(HEAP_DEPTH));
  assign stat.empty    = (count == '0);
  assign stat.at_root  = (pos == COUNT_WIDTH'(1));
  assign stat.no_kids  = (left_pos > count_ext);
  assign stat.go_up    = (elem_prio < a_prio);
  assign stat.go_down  = (elem_prio > child_elem[EW-1 -: PRIORITY_WIDTH]);
  assign stat.out_busy = out_valid && !out_ready;

  always_comb begin
    addr_a = slot(pos >> 1);
    addr_b = slot(count);
    priority if (cmd.read_ends) begin
      addr_a = '0;
      addr_b = slot(count);
    end else if (cmd.read_kids) begin
      addr_a = left_addr_w[AW-1:0];
      addr_b = left_pos[AW-1:0];
    end else if (cmd.read_parent) begin
      addr_a = slot(pos >> 1);
    end
  end

  assign wr_en   = cmd.place_new | cmd.move_up | cmd.move_down | cmd.place_last;
  assign wr_addr = slot(pos);
  assign wr_data = cmd.move_up ? rd_a : (cmd.move_down ? child_elem : elem);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.place_new) begin
        count <= count + COUNT_WIDTH'(1);
      end else if (cmd.place_last) begin
        count <= count - COUNT_WIDTH'(1);
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      elem     <= {item_priority, item_data};
      pos      <= count + COUNT_WIDTH'(1);
      top_data <= '0;
    end else if (cmd.load_last) begin
      elem     <= rd_b;
      top_data <= rd_a[DATA_WIDTH-1:0];
      pos      <= COUNT_WIDTH'(1);
    end else if (cmd.move_up) begin
      pos <= pos >> 1;
    end else if (cmd.move_down) begin
      pos <= child_pos;
    end
    if (cmd.publish) begin
      out_data   <= top_data;
      out_status <= cmd.code;
      out_count  <= count;
      out_empty  <= (count == '0);
    end
  end

endmodule

// ===== hw/rtl/hpq_checker.sv =====
// port-level checks for the priority queue, bound to the top level
// depends on hpq_pkg and binary_min_heap_priority_queue

module hpq_checker #(
  parameter int HEAP_DEPTH  = hpq_pkg::HPQ_HEAP_DEPTH,
  parameter int DATA_WIDTH  = hpq_pkg::HPQ_DATA_WIDTH,
  parameter int COUNT_WIDTH = $clog2(hpq_pkg::HPQ_HEAP_DEPTH + 1)
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [DATA_WIDTH-1:0]  rsp_out_data,
  input hpq_pkg::status_t       rsp_status,
  input logic [COUNT_WIDTH-1:0] rsp_count,
  input logic                   rsp_is_empty
);
  import hpq_pkg::*;

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_data) && $stable(rsp_count))
    else $error("result changed while stalled");

  // one item at a time: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item accepted while busy");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_is_empty == (rsp_count == '0)) &&
                  (rsp_count <= COUNT_WIDTH'(HEAP_DEPTH)))
    else $error("count and empty flag disagree");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != STATUS_OK) |-> rsp_out_data == '0)
    else $error("refused item returned data");

  a_refused_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status != STATUS_FULL || rsp_count == COUNT_WIDTH'(HEAP_DEPTH)) &&
                  (rsp_status != STATUS_EMPTY || rsp_is_empty))
    else $error("refusal status inconsistent with count");

endmodule

bind binary_min_heap_priority_queue hpq_checker #(
  .HEAP_DEPTH  (HEAP_DEPTH),
  .DATA_WIDTH  (DATA_WIDTH),
  .COUNT_WIDTH (COUNT_WIDTH)
) u_hpq_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_out_data (rsp.out_data),
  .rsp_status   (rsp.status),
  .rsp_count    (rsp.count),
  .rsp_is_empty (rsp.is_empty)
);

// ===== dv/binary_min_heap_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// testbench for binary_min_heap_priority_queue: drives insert/delete items and
// checks every result against a behavioral min-heap kept alongside
// depends on hpq_pkg, hpq_in_if, hpq_out_if and the rtl top level

module binary_min_heap_priority_queue_tb;
  import hpq_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int DEPTH        = HPQ_HEAP_DEPTH;
  localparam int DW           = HPQ_DATA_WIDTH;
  localparam int PW           = HPQ_PRIO_WIDTH;
  localparam int CW           = $clog2(DEPTH + 1);
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 3000;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // priority shapes used by the random traffic
  typedef enum int {PRIO_FULL, PRIO_NARROW, PRIO_EDGES} prio_mode_t;

  typedef struct packed {
    logic [PW-1:0] prio;
    logic [DW-1:0] data;
  } heap_entry_t;

  typedef struct packed {
    logic [DW-1:0] out_data;
    status_t       status;
    logic [CW-1:0] count;
    logic          is_empty;
  } heap_result_t;

  logic clk;
  logic rst;

  hpq_in_if  req ();
  hpq_out_if rsp ();

  binary_min_heap_priority_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  heap_entry_t  heap_slots [1:DEPTH];
  int           heap_size;
  heap_result_t pending_results [$];
  int           fail_count;
  bit           src_idle_on;
  bit           sink_idle_on;
  int           hold_left;
  int           stall_left;
  int           quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // min-heap update for one accepted item, queues the result it must produce
  task automatic heap_model_apply(input logic act, input logic [DW-1:0] d,
                                  input logic [PW-1:0] p);
    heap_result_t res;
    heap_entry_t  last;
    int           pos;
    int           left;
    int           child;
    res.out_data = '0;
    res.status   = STATUS_OK;
    if (act == ACT_INSERT) begin
      if (heap_size >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        pos = heap_size + 1;
        while (pos != 1 && p < heap_slots[pos / 2].prio) begin
          heap_slots[pos] = heap_slots[pos / 2];
          pos = pos / 2;
        end
        heap_slots[pos] = '{prio: p, data: d};
        heap_size++;
      end
    end else if (heap_size == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.out_data = heap_slots[1].data;
      last = heap_slots[heap_size];
      pos = 1;
      forever begin
        left = pos * 2;
        if (left > heap_size) break;
        child = left;
        // right child only when strictly smaller, left wins ties
        if (left < heap_size && heap_slots[left].prio > heap_slots[left + 1].prio)
          child = left + 1;
        if (last.prio <= heap_slots[child].prio) break;
        heap_slots[pos] = heap_slots[child];
        pos = child;
      end
      heap_slots[pos] = last;
      heap_size--;
    end
    res.count    = CW'(heap_size);
    res.is_empty = (heap_size == 0);
    pending_results.push_back(res);
  endtask

  task automatic send_item(input logic act, input logic [DW-1:0] d,
                           input logic [PW-1:0] p);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.action        <= act;
    req.item_data     <= d;
    req.item_priority <= p;
    do @(posedge clk); while (!req.ready);
    heap_model_apply(act, d, p);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PW-1:0] pick_prio(input prio_mode_t mode);
    case (mode)
      PRIO_NARROW: return PW'($urandom_range(0, 7));
      PRIO_EDGES:  return ($urandom_range(0, 1) != 0) ? {PW{1'b1}} : '0;
      default:     return PW'($urandom);
    endcase
  endfunction

  task automatic test_empty_delete();
    send_item(ACT_DELETE, '0, '0);
    send_item(ACT_DELETE, {DW{1'b1}}, {PW{1'b1}});
  endtask

  task automatic test_field_extremes();
    send_item(ACT_INSERT, {DW{1'b1}}, {PW{1'b1}});
    send_item(ACT_INSERT, '0, '0);
    send_item(ACT_INSERT, 32'hA5A5_A5A5, 16'h8000);
    send_item(ACT_INSERT, 32'h5A5A_5A5A, 16'h7FFF);
    repeat (4) send_item(ACT_DELETE, 32'hDEAD_BEEF, 16'h1234);
    send_item(ACT_DELETE, '0, '0);
  endtask

  task automatic test_priority_ties();
    for (int i = 0; i < 5; i++) send_item(ACT_INSERT, DW'(32'h100 + i), 16'd3);
    send_item(ACT_INSERT, 32'h0000_0001, 16'd1);
    send_item(ACT_INSERT, 32'h0000_0005, 16'd5);
    repeat (7) send_item(ACT_DELETE, '0, '0);
  endtask

  // fill to the top, knock on the full heap, then drain past empty
  task automatic test_fill_to_capacity();
    for (int i = 0; i < DEPTH; i++)
      send_item(ACT_INSERT, DW'($urandom), pick_prio(prio_mode_t'($urandom_range(0, 2))));
    repeat (3) send_item(ACT_INSERT, DW'($urandom), PW'($urandom));
    repeat (DEPTH + 2) send_item(ACT_DELETE, DW'($urandom), PW'($urandom));
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    hold_left = 240;
    for (int i = 0; i < 16; i++)
      send_item(logic'(i % 4 == 3), DW'($urandom), PW'($urandom));
  endtask

  task automatic test_sender_pause();
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 20; i++)
        send_item(logic'($urandom_range(0, 2) == 0), DW'($urandom), PW'($urandom));
      wait_drained();
    end
  endtask

  // phases lean toward insert or delete so the count sweeps the whole range
  task automatic test_random_traffic(input int n_items);
    int         sent;
    int         phase_len;
    int         insert_pct;
    prio_mode_t mode;
    sent = 0;
    while (sent < n_items) begin
      phase_len    = $urandom_range(20, 120);
      insert_pct   = ($urandom_range(0, 2) == 0) ? 10 : ($urandom_range(0, 1) ? 50 : 85);
      mode         = prio_mode_t'($urandom_range(0, 2));
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < phase_len && sent < n_items; i++) begin
        send_item(logic'($urandom_range(1, 100) > insert_pct), DW'($urandom),
                  pick_prio(mode));
        sent++;
      end
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic test_no_idle(input int n_items);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    for (int i = 0; i < n_items; i++)
      send_item(logic'($urandom_range(0, 1)), DW'($urandom),
                pick_prio(prio_mode_t'($urandom_range(0, 2))));
  endtask

  // result receiver: long hold when asked, else random stall bursts
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    heap_result_t exp;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: out_data %0h status %0d count %0d",
               rsp.out_data, rsp.status, rsp.count);
        fail_count++;
      end else begin
        exp = pending_results.pop_front();
        if (rsp.out_data !== exp.out_data) begin
          $error("out_data: expected %0h, actual %0h", exp.out_data, rsp.out_data);
          fail_count++;
        end
        if (rsp.status !== exp.status) begin
          $error("status: expected %0d, actual %0d", exp.status, rsp.status);
          fail_count++;
        end
        if (rsp.count !== exp.count) begin
          $error("count: expected %0d, actual %0d", exp.count, rsp.count);
          fail_count++;
        end
        if (rsp.is_empty !== exp.is_empty) begin
          $error("is_empty: expected %0d, actual %0d", exp.is_empty, rsp.is_empty);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    heap_size    = 0;
    fail_count   = 0;
    hold_left    = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    rst               <= 1'b1;
    req.valid         <= 1'b0;
    req.action        <= ACT_INSERT;
    req.item_data     <= '0;
    req.item_priority <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_delete();
    test_field_extremes();
    test_priority_ties();
    test_fill_to_capacity();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic(1100);
    test_no_idle(200);

    wait_drained();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== binary_min_heap_priority_queue.f =====
hw/rtl/hpq_pkg.sv
hw/rtl/hpq_in_if.sv
hw/rtl/hpq_out_if.sv
hw/rtl/hpq_ctrl.sv
hw/rtl/hpq_datapath.sv
hw/rtl/binary_min_heap_priority_queue.sv
hw/rtl/hpq_checker.sv
dv/binary_min_heap_priority_queue_tb.sv
